>>> rtl/lrc_pkg.sv
package lrc_pkg;

	localparam int RANGE_W = 16;
	localparam int IDX_W = 16;
	localparam int CURV_W = 32;

	localparam int MAX_SCAN_POINTS = 65536;
	localparam int HALF_WINDOW = 5;
	localparam int WIN_SPAN = 2 * HALF_WINDOW;
	localparam int WIN_LEN = WIN_SPAN + 1;
	localparam int IDX_MOD = (MAX_SCAN_POINTS > 65536) ? 65536 : MAX_SCAN_POINTS;
	localparam int FILL_W = $clog2(WIN_SPAN + 1);
	localparam int K_W = $clog2(WIN_LEN);

	// residual e = 10*(Rk-R0) - k*(R10-R0), |e| < 2^21
	localparam int E_W = 22;
	localparam int MAG_W = 21;
	localparam int SQ_W = 2 * MAG_W;
	localparam int SUM_W = 44;
	// curvature = floor(S*2560 / (900*R5)) = floor(S*128 / (45*R5))
	localparam int NUM_SHIFT = 7;
	localparam int NUM_W = SUM_W + NUM_SHIFT;
	localparam int DEN_MUL = 45;
	localparam int DEN_W = 22;
	localparam int REM_W = DEN_W + 1;
	localparam int TOP_W = NUM_W - CURV_W;
	localparam int STEP_W = $clog2(CURV_W);

	localparam logic [CURV_W-1:0] CURV_MAX = '1;

	localparam int QUEUE_DEPTH = 2;
	localparam int QPTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);

	typedef struct packed {
		logic [WIN_LEN-1:0][RANGE_W-1:0] win;
		logic [IDX_W-1:0] center_index;
	} job_t;

	typedef struct packed {
		logic full;
		logic empty;
	} q_status_t;

endpackage

>>> rtl/lrc_ifs.sv
interface lrc_in_if;
	import lrc_pkg::*;
	logic valid;
	logic ready;
	logic [RANGE_W-1:0] range_sample;
	logic scan_start;
	modport source(output valid, range_sample, scan_start, input ready);
	modport sink(input valid, range_sample, scan_start, output ready);
endinterface

interface lrc_out_if;
	import lrc_pkg::*;
	logic valid;
	logic ready;
	logic [CURV_W-1:0] curvature;
	logic [IDX_W-1:0] center_index;
	logic zero_range;
	modport source(output valid, curvature, center_index, zero_range, input ready);
	modport sink(input valid, curvature, center_index, zero_range, output ready);
endinterface

>>> rtl/lrc_front.sv
module lrc_front (
	input logic clk,
	input logic arst_n,
	lrc_in_if.sink samples,
	input lrc_pkg::q_status_t q_status,
	output logic push,
	output lrc_pkg::job_t push_job
);
	import lrc_pkg::*;

	logic [WIN_SPAN-1:0][RANGE_W-1:0] win_q;
	logic [FILL_W-1:0] fill_q;
	logic [FILL_W-1:0] fill_eff;
	logic [IDX_W-1:0] cnt_q;
	logic [IDX_W-1:0] cnt_eff;
	logic [IDX_W:0] cnt_wide;
	logic [IDX_W:0] cnt_next;
	logic [IDX_W:0] ci_wide;
	logic accept;

	assign samples.ready = !q_status.full;
	assign accept = samples.valid && samples.ready;

	assign fill_eff = samples.scan_start ? '0 : fill_q;
	assign cnt_eff = samples.scan_start ? '0 : cnt_q;
	assign cnt_wide = {1'b0, cnt_eff};
	assign cnt_next = (cnt_wide + (IDX_W+1)'(1) >= (IDX_W+1)'(IDX_MOD)) ? '0
		: cnt_wide + (IDX_W+1)'(1);
	assign ci_wide = (cnt_wide >= (IDX_W+1)'(HALF_WINDOW))
		? cnt_wide - (IDX_W+1)'(HALF_WINDOW)
		: cnt_wide + (IDX_W+1)'(IDX_MOD - HALF_WINDOW);

	assign push = accept && (fill_eff == FILL_W'(WIN_SPAN));

	always_comb begin
		for (int i = 0; i < WIN_SPAN; i++) begin
			push_job.win[i] = win_q[i];
		end
		push_job.win[WIN_SPAN] = samples.range_sample;
		push_job.center_index = ci_wide[IDX_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q <= '0;
			cnt_q <= '0;
		end else if (accept) begin
			fill_q <= (fill_eff < FILL_W'(WIN_SPAN)) ? fill_eff + FILL_W'(1) : fill_eff;
			cnt_q <= cnt_next[IDX_W-1:0];
		end
	end

	// shift the window, oldest at index zero
	always_ff @(posedge clk) begin
		if (accept) begin
			for (int i = 0; i < WIN_SPAN - 1; i++) begin
				win_q[i] <= win_q[i+1];
			end
			win_q[WIN_SPAN-1] <= samples.range_sample;
		end
	end

endmodule

>>> rtl/lrc_queue.sv
module lrc_queue (
	input logic clk,
	input logic arst_n,
	input logic push,
	input lrc_pkg::job_t push_job,
	input logic pop,
	output lrc_pkg::job_t head_job,
	output lrc_pkg::q_status_t q_status
);
	import lrc_pkg::*;

	job_t mem_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] cnt_q;

	assign q_status.full = (cnt_q == QCNT_W'(QUEUE_DEPTH));
	assign q_status.empty = (cnt_q == '0);
	assign head_job = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + QPTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + QPTR_W'(1);
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + QCNT_W'(1);
			end else if (pop && !push) begin
				cnt_q <= cnt_q - QCNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_job;
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !q_status.full)
		else $error("queue push while full");

	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> !q_status.empty)
		else $error("queue pop while empty");

endmodule

>>> rtl/lrc_back.sv
module lrc_back (
	input logic clk,
	input logic arst_n,
	input lrc_pkg::q_status_t q_status,
	input lrc_pkg::job_t head_job,
	output logic pop,
	lrc_out_if.source results
);
	import lrc_pkg::*;

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_SUMS = 3'd1;
	localparam logic [2:0] ST_PREP = 3'd2;
	localparam logic [2:0] ST_CHECK = 3'd3;
	localparam logic [2:0] ST_DIV = 3'd4;
	localparam logic [2:0] ST_DONE = 3'd5;

	logic [2:0] state_q;
	job_t job_q;
	logic signed [E_W-1:0] span_q;
	logic [K_W-1:0] k_q;
	logic issue;
	logic signed [E_W-1:0] dk;
	logic signed [E_W-1:0] kspan;
	logic signed [E_W-1:0] e_next;
	logic signed [E_W-1:0] e_s1;
	logic v_s1;
	logic [E_W-1:0] e_abs;
	logic [MAG_W-1:0] mag;
	logic [SQ_W-1:0] sq_s2;
	logic v_s2;
	logic [SUM_W-1:0] sum_q;
	logic [NUM_W-1:0] num;
	logic [DEN_W-1:0] den_q;
	logic [DEN_W-1:0] rem_q;
	logic [CURV_W-1:0] quo_q;
	logic [STEP_W-1:0] step_q;
	logic sat_q;
	logic zero_q;
	logic [REM_W-1:0] cand;
	logic cand_ge;
	logic [REM_W-1:0] cand_sub;
	logic out_valid_q;
	logic [CURV_W-1:0] curv_q;
	logic [IDX_W-1:0] idx_q;
	logic zr_q;
	logic load_out;

	assign pop = (state_q == ST_IDLE) && !q_status.empty;
	assign issue = (state_q == ST_SUMS) && (k_q != K_W'(WIN_SPAN));

	assign dk = $signed(E_W'(job_q.win[k_q])) - $signed(E_W'(job_q.win[0]));
	assign kspan = span_q * $signed(E_W'(k_q));
	assign e_next = (dk <<< 3) + (dk <<< 1) - kspan;

	assign e_abs = e_s1[E_W-1] ? E_W'(-e_s1) : E_W'(e_s1);
	assign mag = e_abs[MAG_W-1:0];

	assign num = {sum_q, NUM_SHIFT'(0)};

	assign cand = {rem_q, quo_q[CURV_W-1]};
	assign cand_ge = (cand >= {1'b0, den_q});
	assign cand_sub = cand - {1'b0, den_q};

	assign load_out = (state_q == ST_DONE) && (!out_valid_q || results.ready);

	assign results.valid = out_valid_q;
	assign results.curvature = curv_q;
	assign results.center_index = idx_q;
	assign results.zero_range = zr_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			k_q <= '0;
			step_q <= '0;
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			v_s1 <= issue;
			v_s2 <= v_s1;
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (results.ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (pop) begin
						k_q <= K_W'(1);
						state_q <= ST_SUMS;
					end
				end
				ST_SUMS: begin
					if (issue) begin
						k_q <= k_q + K_W'(1);
					end else if (!v_s1 && !v_s2) begin
						state_q <= ST_PREP;
					end
				end
				ST_PREP: begin
					state_q <= ST_CHECK;
				end
				ST_CHECK: begin
					step_q <= '0;
					state_q <= (rem_q >= den_q) ? ST_DONE : ST_DIV;
				end
				ST_DIV: begin
					step_q <= step_q + STEP_W'(1);
					if (step_q == STEP_W'(CURV_W - 1)) begin
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (load_out) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		e_s1 <= e_next;
		sq_s2 <= mag * mag;
		if (pop) begin
			job_q <= head_job;
			span_q <= $signed(E_W'(head_job.win[WIN_SPAN])) - $signed(E_W'(head_job.win[0]));
			sum_q <= '0;
		end else if (v_s2) begin
			sum_q <= sum_q + SUM_W'(sq_s2);
		end
		if (state_q == ST_PREP) begin
			den_q <= DEN_W'(job_q.win[HALF_WINDOW] * DEN_W'(DEN_MUL));
			zero_q <= (job_q.win[HALF_WINDOW] == '0);
			rem_q <= DEN_W'(num[NUM_W-1:CURV_W]);
			quo_q <= num[CURV_W-1:0];
		end
		if (state_q == ST_CHECK) begin
			sat_q <= (rem_q >= den_q);
		end
		if (state_q == ST_DIV) begin
			rem_q <= cand_ge ? cand_sub[DEN_W-1:0] : cand[DEN_W-1:0];
			quo_q <= {quo_q[CURV_W-2:0], cand_ge};
		end
		if (load_out) begin
			curv_q <= sat_q ? CURV_MAX : quo_q;
			idx_q <= job_q.center_index;
			zr_q <= zero_q;
		end
	end

	a_rem_below_den: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DIV) |-> (rem_q < den_q))
		else $error("divider remainder not below divisor");

	a_zero_never_divides: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DIV) |-> !zero_q)
		else $error("zero centre range entered divider");

	a_zero_gives_max: assert property (@(posedge clk) disable iff (!arst_n)
		(results.valid && results.zero_range) |-> (results.curvature == CURV_MAX))
		else $error("zero centre range without maximum curvature");

endmodule

>>> rtl/lidar_range_curvature.sv
// Lidar scan-line curvature.
// samples: one range per transfer (1/256 m) plus scan_start marking the first
// point of a scan. results: curvature (2^-16 m, saturating), the index of the
// centre point within its scan, and zero_range when the centre range is zero.
// An 11-sample window must be filled within a scan before results appear, so
// the first and last five points of each scan give no result.
// A front stage shifts the window and queues full windows in a 2-entry queue;
// the back end squares and sums the nine residuals with one multiplier and
// then runs a 32-step restoring divider.
// Saturated or zero centre results skip the divider. The back end works on one
// window at a time through its sums, divider and control steps, and takes the
// next only after its result is loaded into the output register; samples that
// give no result are taken every cycle while the queue has room.
// Reset clears the window fill, scan index, queue and output register.
// When results is stalled the finished result holds; the back end waits with
// the next result, the queue fills and then samples.ready drops.
module lidar_range_curvature (
	input logic clk,
	input logic arst_n,
	lrc_in_if.sink samples,
	lrc_out_if.source results
);
	import lrc_pkg::*;

	logic push;
	logic pop;
	job_t push_job;
	job_t head_job;
	q_status_t q_status;

	lrc_front u_front (
		.clk(clk),
		.arst_n(arst_n),
		.samples(samples),
		.q_status(q_status),
		.push(push),
		.push_job(push_job)
	);

	lrc_queue u_queue (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.push_job(push_job),
		.pop(pop),
		.head_job(head_job),
		.q_status(q_status)
	);

	lrc_back u_back (
		.clk(clk),
		.arst_n(arst_n),
		.q_status(q_status),
		.head_job(head_job),
		.pop(pop),
		.results(results)
	);

endmodule
